>>> hw/rtl/imu_gd_pkg.sv
// Package for the IMU gesture detector: item types, configuration record,
// register indexes and gesture codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package imu_gd_pkg;

    // Gesture codes carried in the result item.
    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_ALIGN = 2'd1,
        GEST_WAVE  = 2'd2,
        GEST_FLICK = 2'd3
    } gesture_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_GRAV_TOL   = 3'd0;
    localparam logic [2:0] REG_GYRO_TOL   = 3'd1;
    localparam logic [2:0] REG_HOLD_MS    = 3'd2;
    localparam logic [2:0] REG_WAVE_HIGH  = 3'd3;
    localparam logic [2:0] REG_WAVE_LOW   = 3'd4;
    localparam logic [2:0] REG_WAVE_MAX   = 3'd5;
    localparam logic [2:0] REG_FLICK_THR  = 3'd6;
    localparam logic [2:0] REG_FLICK_MAX  = 3'd7;

    // Reset values of the configuration registers.
    localparam int unsigned RST_GRAV_TOL  = 1638;
    localparam int unsigned RST_GYRO_TOL  = 655;
    localparam int unsigned RST_HOLD_MS   = 500;
    localparam int unsigned RST_WAVE_HIGH = 8192;
    localparam int unsigned RST_WAVE_LOW  = 3277;
    localparam int unsigned RST_WAVE_MAX  = 800;
    localparam int unsigned RST_FLICK_THR = 26200;
    localparam int unsigned RST_FLICK_MAX = 300;

    // Thresholds that are compared against squared magnitudes are kept squared.
    typedef struct packed {
        logic [15:0] grav_tol;
        logic [31:0] gyro_tol_sq;
        logic [15:0] hold_ms;
        logic [31:0] wave_high_sq;
        logic [31:0] wave_low_sq;
        logic [15:0] wave_max_ms;
        logic [31:0] flick_thr_sq;
        logic [15:0] flick_max_ms;
    } imu_gd_cfg_t;

    localparam imu_gd_cfg_t CFG_RESET = '{
        grav_tol:     16'(RST_GRAV_TOL),
        gyro_tol_sq:  32'(RST_GYRO_TOL * RST_GYRO_TOL),
        hold_ms:      16'(RST_HOLD_MS),
        wave_high_sq: 32'(RST_WAVE_HIGH * RST_WAVE_HIGH),
        wave_low_sq:  32'(RST_WAVE_LOW * RST_WAVE_LOW),
        wave_max_ms:  16'(RST_WAVE_MAX),
        flick_thr_sq: 32'(RST_FLICK_THR * RST_FLICK_THR),
        flick_max_ms: 16'(RST_FLICK_MAX)
    };

    // One input item as held in the input register (counts are two's complement).
    typedef struct packed {
        logic        sample_valid;
        logic [15:0] accel_x;
        logic [15:0] accel_y;
        logic [15:0] accel_z;
        logic [15:0] rate_x;
        logic [15:0] rate_y;
        logic [15:0] rate_z;
        logic [31:0] time_ms;
    } imu_gd_sample_t;

    // One item after the squaring stage.
    typedef struct packed {
        logic        sample_valid;
        logic [15:0] mag_ax;
        logic [15:0] mag_ay;
        logic [15:0] mag_az;
        logic [30:0] sq_ax;
        logic [30:0] sq_ay;
        logic [30:0] sq_az;
        logic [30:0] sq_gx;
        logic [30:0] sq_gy;
        logic [30:0] sq_gz;
        logic [31:0] time_ms;
    } imu_gd_sq_t;

endpackage

`default_nettype wire

>>> hw/rtl/imu_gd_cfg.sv
// Configuration register file of the IMU gesture detector.
// Squares thresholds on write so the datapath compares squares directly.
// Depends on imu_gd_pkg.
`default_nettype none

module imu_gd_cfg
    import imu_gd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,
    output imu_gd_cfg_t      cfg
);

    imu_gd_cfg_t cfg_reg;
    logic [31:0] data_sq;

    // One shared multiplier squares the written value.
    assign data_sq = 32'(wr_data) * 32'(wr_data);

    // Register writes; every index of the 3-bit field names a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_GRAV_TOL:  cfg_reg.grav_tol     <= wr_data;
                REG_GYRO_TOL:  cfg_reg.gyro_tol_sq  <= data_sq;
                REG_HOLD_MS:   cfg_reg.hold_ms      <= wr_data;
                REG_WAVE_HIGH: cfg_reg.wave_high_sq <= data_sq;
                REG_WAVE_LOW:  cfg_reg.wave_low_sq  <= data_sq;
                REG_WAVE_MAX:  cfg_reg.wave_max_ms  <= wr_data;
                REG_FLICK_THR: cfg_reg.flick_thr_sq <= data_sq;
                REG_FLICK_MAX: cfg_reg.flick_max_ms <= wr_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/imu_gd_sq.sv
// Squaring stage of the IMU gesture detector: axis magnitudes and squares.
// Six 16x16 multipliers feed one register stage.
// Depends on imu_gd_pkg.
`default_nettype none

module imu_gd_sq
    import imu_gd_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           load,
    input  wire imu_gd_sample_t sample,
    output imu_gd_sq_t          sq
);

    imu_gd_sq_t sq_reg;
    imu_gd_sq_t sq_next;

    // Absolute value of a two's complement count; the most negative one maps to 32768.
    function automatic logic [15:0] mag16(input logic [15:0] v);
        logic [15:0] neg;
        neg = ~v + 16'd1;
        return v[15] ? neg : v;
    endfunction

    // Square of a signed count; at most 2^30, so 31 bits hold it.
    function automatic logic [30:0] sq16(input logic [15:0] v);
        logic signed [31:0] p;
        p = $signed(v) * $signed(v);
        return p[30:0];
    endfunction

    always_comb
    begin
        sq_next.sample_valid = sample.sample_valid;
        sq_next.mag_ax       = mag16(sample.accel_x);
        sq_next.mag_ay       = mag16(sample.accel_y);
        sq_next.mag_az       = mag16(sample.accel_z);
        sq_next.sq_ax        = sq16(sample.accel_x);
        sq_next.sq_ay        = sq16(sample.accel_y);
        sq_next.sq_az        = sq16(sample.accel_z);
        sq_next.sq_gx        = sq16(sample.rate_x);
        sq_next.sq_gy        = sq16(sample.rate_y);
        sq_next.sq_gz        = sq16(sample.rate_z);
        sq_next.time_ms      = sample.time_ms;
    end

    // Payload register, loaded when the item moves on.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule

`default_nettype wire

>>> hw/rtl/imu_gd_decide.sv
// Decision stage of the IMU gesture detector: sums, threshold compares,
// the align/wave/flick detector state and the result register.
// Depends on imu_gd_pkg.
`default_nettype none

module imu_gd_decide
    import imu_gd_pkg::*;
#(
    parameter int unsigned ONE_G_COUNTS = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire imu_gd_sq_t  sq,
    input  wire imu_gd_cfg_t cfg,
    output gesture_t         gesture
);

    localparam logic [15:0] ONE_G = 16'(ONE_G_COUNTS);

    logic [31:0] align_since_reg, align_since_next;
    logic        wave_active_reg, wave_active_next;
    logic [31:0] wave_since_reg, wave_since_next;
    logic        flick_active_reg, flick_active_next;
    logic [31:0] flick_since_reg, flick_since_next;
    gesture_t    gesture_reg, gesture_next;

    logic [31:0] g2;
    logic [31:0] lat2;
    logic [36:0] g2_x25;
    logic [36:0] flick_fall_lim;
    logic        aligned;
    logic [31:0] align_dt;
    logic [31:0] wave_dt;
    logic [31:0] flick_dt;

    // True when dom is within tol of one g and both other axes are below tol.
    function automatic logic axis_dom(input logic [15:0] dom, input logic [15:0] o1,
                                      input logic [15:0] o2, input logic [15:0] tol);
        logic [15:0] diff;
        diff = (dom >= ONE_G) ? (dom - ONE_G) : (ONE_G - dom);
        return (diff < tol) && (o1 < tol) && (o2 < tol);
    endfunction

    // Squared magnitudes; three squares of at most 2^30 still fit 32 bits.
    assign g2   = 32'(sq.sq_gx) + 32'(sq.sq_gy) + 32'(sq.sq_gz);
    assign lat2 = 32'(sq.sq_ax) + 32'(sq.sq_ay);

    // Flick fall test 25*g2 < 4*thr^2, done with shifts and adds.
    assign g2_x25 = (37'(g2) << 4) + (37'(g2) << 3) + 37'(g2);
    assign flick_fall_lim = 37'(cfg.flick_thr_sq) << 2;

    assign aligned = (axis_dom(sq.mag_ax, sq.mag_ay, sq.mag_az, cfg.grav_tol) ||
                      axis_dom(sq.mag_ay, sq.mag_ax, sq.mag_az, cfg.grav_tol) ||
                      axis_dom(sq.mag_az, sq.mag_ax, sq.mag_ay, cfg.grav_tol)) &&
                     (g2 < cfg.gyro_tol_sq);

    // Elapsed times wrap modulo 2^32.
    assign align_dt = sq.time_ms - align_since_reg;
    assign wave_dt  = sq.time_ms - wave_since_reg;
    assign flick_dt = sq.time_ms - flick_since_reg;

    // Detectors in order align, wave, flick; the first one to fire ends the item.
    always_comb
    begin
        align_since_next  = align_since_reg;
        wave_active_next  = wave_active_reg;
        wave_since_next   = wave_since_reg;
        flick_active_next = flick_active_reg;
        flick_since_next  = flick_since_reg;
        gesture_next      = GEST_NONE;

        if (sq.sample_valid)
        begin
            // Align: a zero start time means idle, so a start at time zero is retaken.
            if (aligned)
            begin
                if (align_since_reg == 32'd0)
                begin
                    align_since_next = sq.time_ms;
                end
                else if (align_dt >= 32'(cfg.hold_ms))
                begin
                    align_since_next = 32'd0;
                    gesture_next     = GEST_ALIGN;
                end
            end
            else
            begin
                align_since_next = 32'd0;
            end

            // Wave: timeout is checked before completion.
            if (gesture_next == GEST_NONE)
            begin
                priority if (!wave_active_reg)
                begin
                    if (lat2 > cfg.wave_high_sq)
                    begin
                        wave_active_next = 1'b1;
                        wave_since_next  = sq.time_ms;
                    end
                end
                else if (wave_dt > 32'(cfg.wave_max_ms))
                begin
                    wave_active_next = 1'b0;
                end
                else if (lat2 < cfg.wave_low_sq)
                begin
                    wave_active_next = 1'b0;
                    gesture_next     = GEST_WAVE;
                end
                else
                begin
                    // A wave in progress that has neither timed out nor fallen goes on.
                    wave_active_next = wave_active_reg;
                end
            end

            // Flick: same shape as the wave detector.
            if (gesture_next == GEST_NONE)
            begin
                priority if (!flick_active_reg)
                begin
                    if (g2 > cfg.flick_thr_sq)
                    begin
                        flick_active_next = 1'b1;
                        flick_since_next  = sq.time_ms;
                    end
                end
                else if (flick_dt > 32'(cfg.flick_max_ms))
                begin
                    flick_active_next = 1'b0;
                end
                else if (g2_x25 < flick_fall_lim)
                begin
                    flick_active_next = 1'b0;
                    gesture_next      = GEST_FLICK;
                end
                else
                begin
                    // A flick in progress that has neither timed out nor fallen goes on.
                    flick_active_next = flick_active_reg;
                end
            end
        end
    end

    // Detector state and result register advance once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_since_reg  <= 32'd0;
            wave_active_reg  <= 1'b0;
            wave_since_reg   <= 32'd0;
            flick_active_reg <= 1'b0;
            flick_since_reg  <= 32'd0;
            gesture_reg      <= GEST_NONE;
        end
        else if (step)
        begin
            align_since_reg  <= align_since_next;
            wave_active_reg  <= wave_active_next;
            wave_since_reg   <= wave_since_next;
            flick_active_reg <= flick_active_next;
            flick_since_reg  <= flick_since_next;
            gesture_reg      <= gesture_next;
        end
    end

    assign gesture = gesture_reg;

`ifndef SYNTH
    // An invalid sample yields no gesture.
    a_invalid_none: assert property (@(posedge clk) disable iff (!rst_n)
        step && !sq.sample_valid |=> gesture_reg == GEST_NONE)
        else $error("invalid sample produced a gesture");

    // Detector state only moves when an item is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(align_since_reg) && $stable(wave_active_reg) &&
                  $stable(flick_active_reg) && $stable(gesture_reg))
        else $error("detector state changed without an item");

    // An align detection returns the align detector to idle.
    a_align_clear: assert property (@(posedge clk) disable iff (!rst_n)
        step && gesture_next == GEST_ALIGN |=> align_since_reg == 32'd0)
        else $error("align fired but start time not cleared");

    // A wave can only complete out of an active wave, which it then ends.
    a_wave_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && gesture_next == GEST_WAVE |-> wave_active_reg ##1 !wave_active_reg)
        else $error("wave result without an active wave");

    // A flick can only complete out of an active flick, which it then ends.
    a_flick_done: assert property (@(posedge clk) disable iff (!rst_n)
        step && gesture_next == GEST_FLICK |-> flick_active_reg ##1 !flick_active_reg)
        else $error("flick result without an active flick");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/imu_gesture_detector.sv
// IMU gesture detector: one gesture code per accepted IMU sample.
// The sample passes the squaring register, then the result register; the result
// is held while m_tready stalls. Throughput: one item per cycle unless m_tready
// stalls; detector state lives in the single decision stage.
// Reset: configuration returns to its defaults, all detectors go idle and
// the pipeline empties. Depends on imu_gd_pkg, imu_gd_cfg, imu_gd_sq, imu_gd_decide.
`default_nettype none

module imu_gesture_detector
    import imu_gd_pkg::*;
#(
    parameter int unsigned ONE_G_COUNTS = 16384
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], rate_x[63:48],
    // rate_y[79:64], rate_z[95:80], time_ms[127:96]
    input  wire logic [127:0] s_tdata,
    // sample_valid[0]
    input  wire logic         s_tuser,

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // gesture[1:0], zeros above
    output logic [7:0]        m_tdata,

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    imu_gd_sample_t sample_reg;
    logic           v1_reg, v2_reg, v3_reg;
    logic           ready1, ready2, ready3;
    imu_gd_cfg_t    cfg;
    imu_gd_sq_t     sq;
    gesture_t       gesture;

    // Per-stage ready; a stage moves when it is empty or its successor moves.
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && ready1)
        begin
            sample_reg.sample_valid <= s_tuser;
            sample_reg.accel_x      <= s_tdata[15:0];
            sample_reg.accel_y      <= s_tdata[31:16];
            sample_reg.accel_z      <= s_tdata[47:32];
            sample_reg.rate_x       <= s_tdata[63:48];
            sample_reg.rate_y       <= s_tdata[79:64];
            sample_reg.rate_z       <= s_tdata[95:80];
            sample_reg.time_ms      <= s_tdata[127:96];
        end
    end

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    imu_gd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    imu_gd_sq u_sq (
        .clk    (clk),
        .load   (v1_reg && ready2),
        .sample (sample_reg),
        .sq     (sq)
    );

    imu_gd_decide #(
        .ONE_G_COUNTS (ONE_G_COUNTS)
    ) u_decide (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (v2_reg && ready3),
        .sq      (sq),
        .cfg     (cfg),
        .gesture (gesture)
    );

    // Result channel.
    assign m_tvalid = v3_reg;
    assign m_tdata  = {6'd0, gesture};

endmodule

`default_nettype wire

>>> verif/tb_imu_gesture_detector.sv
// Self-checking testbench for imu_gesture_detector: drives IMU sample items on the
// stream input, predicts each gesture code and checks the result stream in order.
// Depends on imu_gd_pkg and the imu_gesture_detector RTL only.
module tb_imu_gesture_detector;
    import imu_gd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ONE_G        = 16384;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 255;
    localparam int REPORT_CAP   = 100;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    imu_gesture_detector #(.ONE_G_COUNTS(ONE_G)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the configuration registers.
    logic [15:0] grav_tol  = 16'(RST_GRAV_TOL);
    logic [15:0] gyro_tol  = 16'(RST_GYRO_TOL);
    logic [15:0] hold_ms   = 16'(RST_HOLD_MS);
    logic [15:0] wave_high = 16'(RST_WAVE_HIGH);
    logic [15:0] wave_low  = 16'(RST_WAVE_LOW);
    logic [15:0] wave_max  = 16'(RST_WAVE_MAX);
    logic [15:0] flick_thr = 16'(RST_FLICK_THR);
    logic [15:0] flick_max = 16'(RST_FLICK_MAX);

    // Detector state as the block should hold it.
    logic [31:0] align_start = '0;
    logic        wave_on     = 1'b0;
    logic [31:0] wave_t0     = '0;
    logic        flick_on    = 1'b0;
    logic [31:0] flick_t0    = '0;

    imu_gd_sample_t pending_samples[$];
    gesture_t       expected_gestures[$];

    imu_gd_sample_t offered;
    logic [31:0]    sample_time = '0;
    int             step_max = 274;
    int             samples_queued = 0;
    int             samples_sent = 0;
    int             results_checked = 0;
    int             error_count = 0;
    int             regs_written = 0;
    int             settings_run = 1;
    int             gestures_seen[4] = '{0, 0, 0, 0};
    int             cycle_count = 0;
    int             burst_left = 1;
    int             gap_left = 0;
    int             rx_mode = 0;
    int             rx_mode_left = 0;
    int             rx_count = 0;
    int             hold_req_cnt = 0;
    int             hold_served = 0;
    int             hold_left = 0;
    int             held_cycles = 0;

    // True when the given axis sits within tolerance of one g and the others are small.
    function automatic bit near_one_g(longint unsigned dom, longint unsigned o1,
                                      longint unsigned o2, longint unsigned tol);
        longint unsigned dev;
        dev = (dom > ONE_G) ? dom - ONE_G : ONE_G - dom;
        return (dev < tol) && (o1 < tol) && (o2 < tol);
    endfunction

    // Gesture decision for one sample; updates the shadow detector state.
    function automatic gesture_t classify_sample(imu_gd_sample_t s);
        longint          ax, ay, az, gx, gy, gz;
        longint unsigned mx, my, mz, g2, lat2, tol, gyro2, hi2, lo2, ft2;
        logic [31:0]     elapsed;
        bit              aligned;
        ax = $signed(s.accel_x);
        ay = $signed(s.accel_y);
        az = $signed(s.accel_z);
        gx = $signed(s.rate_x);
        gy = $signed(s.rate_y);
        gz = $signed(s.rate_z);
        mx = (ax < 0) ? -ax : ax;
        my = (ay < 0) ? -ay : ay;
        mz = (az < 0) ? -az : az;
        g2 = gx * gx + gy * gy + gz * gz;
        lat2 = ax * ax + ay * ay;
        tol = grav_tol;
        gyro2 = longint'(gyro_tol) * longint'(gyro_tol);
        hi2 = longint'(wave_high) * longint'(wave_high);
        lo2 = longint'(wave_low) * longint'(wave_low);
        ft2 = longint'(flick_thr) * longint'(flick_thr);

        // An invalid sample yields no gesture and leaves the state alone.
        if (!s.sample_valid)
            return GEST_NONE;

        aligned = (near_one_g(mx, my, mz, tol) || near_one_g(my, mx, mz, tol) ||
                   near_one_g(mz, mx, my, tol)) && (g2 < gyro2);

        // Align: a start at time zero leaves the timer idle.
        if (aligned)
        begin
            elapsed = s.time_ms - align_start;
            if (align_start == 0)
                align_start = s.time_ms;
            else if (elapsed >= {16'd0, hold_ms})
            begin
                align_start = '0;
                return GEST_ALIGN;
            end
        end
        else
            align_start = '0;

        // Wave: timeout is tested before completion.
        elapsed = s.time_ms - wave_t0;
        if (!wave_on)
        begin
            if (lat2 > hi2)
            begin
                wave_on = 1'b1;
                wave_t0 = s.time_ms;
            end
        end
        else if (elapsed > {16'd0, wave_max})
            wave_on = 1'b0;
        else if (lat2 < lo2)
        begin
            wave_on = 1'b0;
            return GEST_WAVE;
        end

        // Flick: the fall test is 25*g^2 < 4*threshold^2.
        elapsed = s.time_ms - flick_t0;
        if (!flick_on)
        begin
            if (g2 > ft2)
            begin
                flick_on = 1'b1;
                flick_t0 = s.time_ms;
            end
        end
        else if (elapsed > {16'd0, flick_max})
            flick_on = 1'b0;
        else if (25 * g2 < 4 * ft2)
        begin
            flick_on = 1'b0;
            return GEST_FLICK;
        end

        return GEST_NONE;
    endfunction

    // Stimulus helpers.
    function automatic logic [15:0] sat16(int v);
        int c;
        c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return c[15:0];
    endfunction

    function automatic int rsign(int m);
        return ($urandom_range(0, 1) != 0) ? -m : m;
    endfunction

    function automatic int mag_below(int lim);
        if (lim <= 0)
            return 0;
        return int'($urandom_range(0, lim - 1));
    endfunction

    function automatic int rsigned(int lim);
        return rsign(mag_below(lim));
    endfunction

    function automatic int mag_above(int lim);
        int lo;
        lo = (lim >= 32768) ? 32768 : lim + 1;
        return int'($urandom_range(lo, 32768));
    endfunction

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Next timestamp: mostly small steps, now and then a jump anywhere or near the wrap.
    function automatic logic [31:0] next_time();
        if ($urandom_range(0, 49) == 0)
            sample_time = ($urandom_range(0, 1) != 0) ? $urandom :
                          32'hFFFF_FFFF - $urandom_range(0, 2000);
        else
            sample_time = sample_time + $urandom_range(0, step_max);
        return sample_time;
    endfunction

    task automatic add_sample(bit v, int ax, int ay, int az, int gx, int gy, int gz,
                              logic [31:0] t);
        imu_gd_sample_t s;
        s.sample_valid = v;
        s.accel_x = sat16(ax);
        s.accel_y = sat16(ay);
        s.accel_z = sat16(az);
        s.rate_x = sat16(gx);
        s.rate_y = sat16(gy);
        s.rate_z = sat16(gz);
        s.time_ms = t;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    task automatic add_noise();
        add_sample($urandom_range(0, 9) != 0, rand16(), rand16(), rand16(),
                   rand16(), rand16(), rand16(), next_time());
    endtask

    // Sample with gravity on one axis, small cross axes and a quiet gyro.
    task automatic add_aligned(int axis);
        int d, o1, o2, gl;
        d = rsign(ONE_G + rsigned(int'(grav_tol) / 2));
        o1 = rsigned(int'(grav_tol) / 2);
        o2 = rsigned(int'(grav_tol) / 2);
        gl = int'(gyro_tol) / 2;
        case (axis)
            0: add_sample(1'b1, d, o1, o2, rsigned(gl), rsigned(gl), rsigned(gl), next_time());
            1: add_sample(1'b1, o1, d, o2, rsigned(gl), rsigned(gl), rsigned(gl), next_time());
            default:
                add_sample(1'b1, o1, o2, d, rsigned(gl), rsigned(gl), rsigned(gl), next_time());
        endcase
    endtask

    // Lateral sample: level 0 above the wave threshold, 1 in between, 2 below the low one.
    task automatic add_lateral(int level);
        int a, b, gl;
        gl = int'(flick_thr) / 3;
        case (level)
            0:
            begin
                a = rsign(mag_above(int'(wave_high)));
                b = rsigned(int'(wave_high) / 2);
            end
            1:
            begin
                a = rsigned(int'(wave_high) * 6 / 10);
                b = rsigned(int'(wave_high) * 6 / 10);
            end
            default:
            begin
                a = rsigned(int'(wave_low) * 7 / 10);
                b = rsigned(int'(wave_low) * 7 / 10);
            end
        endcase
        if ($urandom_range(0, 1) != 0)
            add_sample(1'b1, a, b, rand16(), rsigned(gl), rsigned(gl), rsigned(gl), next_time());
        else
            add_sample(1'b1, b, a, rand16(), rsigned(gl), rsigned(gl), rsigned(gl), next_time());
    endtask

    // Gyro sample: a spike above the flick threshold, or one well under 0.4 of it.
    task automatic add_spin(bit spike);
        int g0, g1, g2v, al, sel;
        al = int'(wave_high) * 6 / 10;
        if (spike)
        begin
            g0 = rsign(mag_above(int'(flick_thr)));
            g1 = rsigned(int'(flick_thr) / 2);
            g2v = rsigned(int'(flick_thr) / 2);
        end
        else
        begin
            g0 = rsigned(int'(flick_thr) * 2 / 10);
            g1 = rsigned(int'(flick_thr) * 2 / 10);
            g2v = rsigned(int'(flick_thr) * 2 / 10);
        end
        sel = $urandom_range(0, 2);
        if (sel == 0)
            add_sample(1'b1, rsigned(al), rsigned(al), rand16(), g0, g1, g2v, next_time());
        else if (sel == 1)
            add_sample(1'b1, rsigned(al), rsigned(al), rand16(), g1, g0, g2v, next_time());
        else
            add_sample(1'b1, rsigned(al), rsigned(al), rand16(), g1, g2v, g0, next_time());
    endtask

    // Random part: mostly complete gestures with random content, the rest noise.
    task automatic fill_random(int count);
        int target, kind, n, k, axis;
        target = samples_queued + count;
        while (samples_queued < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 2)
            begin
                n = $urandom_range(2, 8);
                axis = $urandom_range(0, 2);
                for (k = 0; k < n; k++)
                    if ($urandom_range(0, 7) == 0)
                        add_noise();
                    else
                        add_aligned(axis);
            end
            else if (kind <= 4)
            begin
                add_lateral(0);
                n = $urandom_range(0, 2);
                for (k = 0; k < n; k++)
                    if ($urandom_range(0, 9) == 0)
                        add_noise();
                    else
                        add_lateral(1);
                add_lateral(2);
            end
            else if (kind <= 6)
            begin
                add_spin(1'b1);
                if ($urandom_range(0, 3) == 0)
                    add_noise();
                add_spin(1'b0);
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    add_noise();
            end
        end
    endtask

    // Edges of the fields, every gesture and the corner cases, under reset settings.
    task automatic load_directed();
        // Invalid sample with every bit set.
        add_sample(1'b0, -1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF);
        // Negative and positive full scale on every axis.
        add_sample(1'b1, -32768, -32768, -32768, -32768, -32768, -32768, 32'd5);
        add_sample(1'b1, 32767, 32767, 32767, 32767, 32767, 32767, 32'd10);
        // Alignment that begins at time zero, then holds to exactly the hold time.
        add_sample(1'b1, 0, 0, 16384, 0, 0, 0, 32'd0);
        add_sample(1'b1, 100, -100, -16384, 10, -10, 5, 32'd10);
        add_sample(1'b1, 0, 0, 16384, 0, 0, 0, 32'd509);
        add_sample(1'b1, 0, 0, 16384, 0, 0, 0, 32'd510);
        // Wave that completes at exactly its time limit.
        add_sample(1'b1, 20000, 0, 0, 0, 0, 0, 32'd1000);
        add_sample(1'b1, 5000, 5000, 16384, 0, 0, 0, 32'd1100);
        add_sample(1'b1, 3276, 0, 0, 0, 0, 0, 32'd1800);
        // Wave that runs one millisecond over and is dropped.
        add_sample(1'b1, 0, -9000, 0, 0, 0, 0, 32'd2000);
        add_sample(1'b1, 0, 0, 0, 0, 0, 0, 32'd2801);
        // Flick: fall to exactly 0.4 of the threshold does not count, just below does.
        add_sample(1'b1, 0, 0, 0, 26201, 0, 0, 32'd3000);
        add_sample(1'b1, 0, 0, 0, 10480, 0, 0, 32'd3100);
        add_sample(1'b1, 0, 0, 0, 0, 10479, 0, 32'd3300);
        // Flick timeout, then a gyro exactly at the threshold that must not start one.
        add_sample(1'b1, 0, 0, 0, 0, 0, -32768, 32'd4000);
        add_sample(1'b1, 0, 0, 0, 0, 0, 0, 32'd4301);
        add_sample(1'b1, 0, 0, 0, 26200, 0, 0, 32'd4400);
        // Wave across the 32-bit time wrap.
        add_sample(1'b1, -8193, 0, 0, 0, 0, 0, 32'hFFFF_FF00);
        add_sample(1'b1, 0, 0, 0, 0, 0, 0, 32'h0000_0010);
        // Alignment at the edge of every tolerance, and a gyro exactly at its bound.
        add_sample(1'b1, -14747, 1637, -1637, 378, 378, 378, 32'd5000);
        add_sample(1'b1, -14747, 1637, -1637, 378, 378, 378, 32'd5500);
        add_sample(1'b1, 0, 16384, 0, 655, 0, 0, 32'd6000);
        // Alignment broken by a cross axis at the tolerance, then started again.
        add_sample(1'b1, 0, 16384, 0, 0, 0, 0, 32'd7000);
        add_sample(1'b1, 1638, 16384, 0, 0, 0, 0, 32'd7100);
        add_sample(1'b1, 0, 16384, 0, 0, 0, 0, 32'd7700);
        sample_time = 32'd8000;
    endtask

    // One register write; the valid stays up so that writes can follow back to back.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_GRAV_TOL:  grav_tol = val;
            REG_GYRO_TOL:  gyro_tol = val;
            REG_HOLD_MS:   hold_ms = val;
            REG_WAVE_HIGH: wave_high = val;
            REG_WAVE_LOW:  wave_low = val;
            REG_WAVE_MAX:  wave_max = val;
            REG_FLICK_THR: flick_thr = val;
            REG_FLICK_MAX: flick_max = val;
            default: ;
        endcase
        regs_written++;
    endtask

    // Writes a full register set; called on a rising edge with the block idle.
    task automatic program_regs(logic [15:0] gt, logic [15:0] gy, logic [15:0] hm,
                                logic [15:0] wh, logic [15:0] wl, logic [15:0] wm,
                                logic [15:0] ft, logic [15:0] fm);
        int longest;
        write_reg(REG_GRAV_TOL, gt);
        write_reg(REG_GYRO_TOL, gy);
        write_reg(REG_HOLD_MS, hm);
        write_reg(REG_WAVE_HIGH, wh);
        write_reg(REG_WAVE_LOW, wl);
        write_reg(REG_WAVE_MAX, wm);
        write_reg(REG_FLICK_THR, ft);
        write_reg(REG_FLICK_MAX, fm);
        cfg_valid <= 1'b0;
        longest = int'(hold_ms);
        if (int'(wave_max) > longest)
            longest = int'(wave_max);
        if (int'(flick_max) > longest)
            longest = int'(flick_max);
        step_max = longest / 3 + 8;
        settings_run++;
    endtask

    // Waits until every queued item is through and its result checked.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || expected_gestures.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int count, bit long_hold);
        @(negedge clk);
        fill_random(count);
        if (long_hold)
            hold_req_cnt <= hold_req_cnt + 1;
        wait_drained();
    endtask

    // Sequence of phases with register settings between them.
    initial
    begin
        int r_high;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        load_directed();
        wait_drained();

        run_phase(PHASE_ITEMS, 1'b1);

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        run_phase(PHASE_ITEMS, 1'b0);

        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000);
        run_phase(PHASE_ITEMS, 1'b0);

        r_high = $urandom_range(4000, 30000);
        program_regs(16'($urandom_range(200, 4000)), 16'($urandom_range(100, 3000)),
                     16'($urandom_range(0, 1000)), 16'(r_high),
                     16'($urandom_range(500, r_high)), 16'($urandom_range(0, 1000)),
                     16'($urandom_range(5000, 40000)), 16'($urandom_range(0, 600)));
        run_phase(PHASE_ITEMS, 1'b0);

        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_phase(PHASE_ITEMS, 1'b0);

        program_regs(16'(RST_GRAV_TOL), 16'(RST_GYRO_TOL), 16'(RST_HOLD_MS),
                     16'(RST_WAVE_HIGH), 16'(RST_WAVE_LOW), 16'(RST_WAVE_MAX),
                     16'(RST_FLICK_THR), 16'(RST_FLICK_MAX));
        run_phase(PHASE_ITEMS, 1'b1);

        $display("Sent %0d samples under %0d register settings (%0d register writes), %0d results checked.",
                 samples_sent, settings_run, regs_written, results_checked);
        $display("Gestures seen: none %0d, align %0d, wave %0d, flick %0d; output held off %0d cycles in long stalls.",
                 gestures_seen[0], gestures_seen[1], gestures_seen[2], gestures_seen[3],
                 held_cycles);
        if (error_count == 0)
            $display("** imu_gesture_detector: PASSED **");
        else
            $display("** imu_gesture_detector: FAILED **");
        $finish;
    end

    // Sample driver: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_gestures.push_back(classify_sample(offered));
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    offered = pending_samples.pop_front();
                    s_tdata <= {offered.time_ms, offered.rate_z, offered.rate_y,
                                offered.rate_x, offered.accel_z, offered.accel_y,
                                offered.accel_x};
                    s_tuser <= offered.sample_valid;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted here when requested.
    always @(posedge clk)
    begin
        if (hold_req_cnt != hold_served)
        begin
            hold_served <= hold_req_cnt;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            held_cycles++;
        end
    end

    // Result receiver: it switches at random among four stall patterns.
    always @(posedge clk)
    begin
        bit ready_now;
        rx_count++;
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0: ready_now = 1'b1;
            1: ready_now = $urandom_range(0, 1) != 0;
            2: ready_now = $urandom_range(0, 3) == 0;
            default: ready_now = rx_count[2];
        endcase
        m_tready <= ready_now && (hold_left == 0);
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        gesture_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_gestures.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $display("%0t: result with none expected: expected nothing, got gesture %0d",
                             $realtime, m_tdata);
            end
            else
            begin
                want = expected_gestures.pop_front();
                results_checked++;
                if (m_tdata !== {6'd0, want})
                begin
                    error_count++;
                    if (error_count <= REPORT_CAP)
                        $display("%0t: gesture mismatch: expected %0d, got %0d",
                                 $realtime, want, m_tdata);
                end
                else
                    gestures_seen[want]++;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles: %0d samples queued, %0d results outstanding.",
                     cycle_count, pending_samples.size(), expected_gestures.size());
            $display("** imu_gesture_detector: FAILED **");
            $finish;
        end
    end

endmodule
